// File: hw/rtl/bdlp_pkg.sv
// Shared widths, register indexes and reset values for the button debouncer.
package bdlp_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned COUNT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 8'd1;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TIME_RESET = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_TIME_RESET = 16'd1000;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

// File: hw/rtl/bdlp_in_if.sv
// Sample channel: raw button level, timestamp and click counter clear.
interface bdlp_in_if
    import bdlp_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  raw_level;
    t_time now_ms;
    logic  clear_clicks;

    modport source (output valid, output raw_level, output now_ms, output clear_clicks,
                    input ready);
    modport sink (input valid, input raw_level, input now_ms, input clear_clicks,
                  output ready);
endinterface

// File: hw/rtl/bdlp_out_if.sv
// Result channel: event flags, debounced level, click count and hold time.
interface bdlp_out_if
    import bdlp_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   press_event;
    logic   long_event;
    logic   release_event;
    logic   click_event;
    logic   is_held;
    t_count clicks;
    t_time  hold_time;

    modport source (output valid, output press_event, output long_event,
                    output release_event, output click_event, output is_held,
                    output clicks, output hold_time, input ready);
    modport sink (input valid, input press_event, input long_event,
                  input release_event, input click_event, input is_held,
                  input clicks, input hold_time, output ready);
endinterface

// File: hw/rtl/bdlp_cfg_if.sv
// Configuration write channel: register index and write data.
interface bdlp_cfg_if
    import bdlp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/button_debounce_long_press_core.sv
// Button debouncer with long press detection, one sample in and one result out per item.
//
//  Channel   Direction  Contents
//  i_sample  in         raw_level, now_ms, clear_clicks
//  o_result  out        press/long/release/click events, is_held, clicks, hold_time
//  i_cfg     in         index, data (debounce_time, long_press_time)
//
// An item passes from acceptance through an input register, then the phase update
// with two subtract-and-compare paths into the result register.
// A new item is accepted every cycle while the result side keeps up.
// When the result is stalled, the input register still takes one more item.
// Synchronous reset returns the phase to released and clears all counts.
// Configuration writes are always accepted.
module button_debounce_long_press_core
    import bdlp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdlp_in_if.sink    i_sample,
    bdlp_out_if.source o_result,
    bdlp_cfg_if.sink   i_cfg
);

    localparam logic [2:0] PH_RELEASED    = 3'd0;
    localparam logic [2:0] PH_DEB_PRESS   = 3'd1;
    localparam logic [2:0] PH_PRESSED     = 3'd2;
    localparam logic [2:0] PH_LONG        = 3'd3;
    localparam logic [2:0] PH_DEB_RELEASE = 3'd4;

    logic [CFG_DATA_W-1:0] r_debounce_time;
    logic [CFG_DATA_W-1:0] r_long_press_time;

    logic  r_in_valid;
    logic  r_in_level;
    t_time r_in_now;
    logic  r_in_clear;

    logic [2:0] r_phase, n_phase;
    t_time      r_change_stamp, n_change_stamp;
    t_time      r_press_stamp, n_press_stamp;
    logic       r_long_seen, n_long_seen;
    logic       r_held, n_held;
    t_count     r_click_total, n_click_total;

    logic n_ev_press, n_ev_long, n_ev_rel, n_ev_click;

    logic  r_out_valid;
    logic  r_out_press, r_out_long, r_out_rel, r_out_click, r_out_held;
    t_count r_out_clicks;
    t_time  r_out_hold;

    logic  advance;
    t_time since_change;
    t_time since_press;
    logic  debounce_done;
    logic  long_done;

    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= DEBOUNCE_TIME_RESET;
            r_long_press_time <= LONG_PRESS_TIME_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DEBOUNCE_TIME: r_debounce_time <= i_cfg.data;
                REG_LONG_PRESS_TIME: r_long_press_time <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_level <= i_sample.raw_level;
            r_in_now <= i_sample.now_ms;
            r_in_clear <= i_sample.clear_clicks;
        end
    end

    assign since_change = r_in_now - r_change_stamp;
    assign since_press = r_in_now - r_press_stamp;
    assign debounce_done = since_change >= {{(TIME_W-CFG_DATA_W){1'b0}}, r_debounce_time};
    assign long_done = since_press >= {{(TIME_W-CFG_DATA_W){1'b0}}, r_long_press_time};

    always_comb begin
        n_phase = r_phase;
        n_change_stamp = r_change_stamp;
        n_press_stamp = r_press_stamp;
        n_long_seen = r_long_seen;
        n_held = r_held;
        n_click_total = r_click_total;
        n_ev_press = 1'b0;
        n_ev_long = 1'b0;
        n_ev_rel = 1'b0;
        n_ev_click = 1'b0;
        case (r_phase)
            PH_DEB_PRESS: begin
                if (!r_in_level) begin
                    n_phase = PH_RELEASED;
                end else if (debounce_done) begin
                    n_phase = PH_PRESSED;
                    n_held = 1'b1;
                    n_press_stamp = r_in_now;
                    n_long_seen = 1'b0;
                    n_ev_press = 1'b1;
                end
            end
            PH_PRESSED: begin
                if (!r_in_level) begin
                    n_phase = PH_DEB_RELEASE;
                    n_change_stamp = r_in_now;
                end else if (!r_long_seen && long_done) begin
                    n_phase = PH_LONG;
                    n_long_seen = 1'b1;
                    n_ev_long = 1'b1;
                end
            end
            PH_LONG: begin
                if (!r_in_level) begin
                    n_phase = PH_DEB_RELEASE;
                    n_change_stamp = r_in_now;
                end
            end
            PH_DEB_RELEASE: begin
                if (r_in_level) begin
                    n_phase = r_long_seen ? PH_LONG : PH_PRESSED;
                end else if (debounce_done) begin
                    n_phase = PH_RELEASED;
                    n_held = 1'b0;
                    n_ev_rel = 1'b1;
                    if (!r_long_seen) begin
                        n_ev_click = 1'b1;
                        n_click_total = r_click_total + 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_RELEASED;
                if (r_in_level) begin
                    n_phase = PH_DEB_PRESS;
                    n_change_stamp = r_in_now;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
            r_change_stamp <= '0;
            r_press_stamp <= '0;
            r_long_seen <= 1'b0;
            r_held <= 1'b0;
            r_click_total <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_change_stamp <= n_change_stamp;
            r_press_stamp <= n_press_stamp;
            r_long_seen <= n_long_seen;
            r_held <= n_held;
            r_click_total <= r_in_clear ? '0 : n_click_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_press <= n_ev_press;
            r_out_long <= n_ev_long;
            r_out_rel <= n_ev_rel;
            r_out_click <= n_ev_click;
            r_out_held <= n_held;
            r_out_clicks <= n_click_total;
            r_out_hold <= (n_held && !n_ev_press) ? since_press : '0;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.press_event = r_out_press;
    assign o_result.long_event = r_out_long;
    assign o_result.release_event = r_out_rel;
    assign o_result.click_event = r_out_click;
    assign o_result.is_held = r_out_held;
    assign o_result.clicks = r_out_clicks;
    assign o_result.hold_time = r_out_hold;

    a_held_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held == (r_phase == PH_PRESSED || r_phase == PH_LONG || r_phase == PH_DEB_RELEASE))
        else $error("Debounced level disagrees with the phase.");

    a_long_phase_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LONG) |-> r_long_seen)
        else $error("Long press phase entered without the long press being recorded.");

    a_click_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_click) |-> (r_out_rel && !r_out_held))
        else $error("Click reported without a confirmed release.");

    a_hold_zero_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_held) |-> (r_out_hold == '0))
        else $error("Hold time is non-zero while the button is released.");

    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out_press, r_out_long, r_out_rel}))
        else $error("More than one of press, long press and release on one item.");

endmodule

// File: tb/sv/button_debounce_long_press_core_test.sv
// Self-checking testbench for the button debouncer with long press detection.
`timescale 1ns / 100ps

module button_debounce_long_press_core_test;
    import bdlp_pkg::*;

    typedef enum logic [2:0] {
        ST_RELEASED,
        ST_DEB_PRESS,
        ST_PRESSED,
        ST_LONG,
        ST_DEB_RELEASE
    } t_btn_state;

    typedef struct packed {
        logic  raw_level;
        t_time now_ms;
        logic  clear_clicks;
    } t_sample;

    typedef struct packed {
        logic   press_event;
        logic   long_event;
        logic   release_event;
        logic   click_event;
        logic   is_held;
        t_count clicks;
        t_time  hold_time;
    } t_result;

    typedef struct packed {
        logic    raw_level;
        t_time   now_ms;
        logic    clear_clicks;
        logic    typed;
        t_result want;
    } t_directed_row;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = '1;
    localparam int unsigned N_PHASES = 8;
    localparam int unsigned ITEMS_PER_PHASE = 200;

    // Rows marked typed carry their expected result; the rest are predicted.
    localparam t_directed_row DIRECTED_ROWS [23] = '{
        '{0, 32'd0,          0, 1, '{0, 0, 0, 0, 0, 32'd0, 32'd0}},
        '{1, 32'd100,        0, 1, '{0, 0, 0, 0, 0, 32'd0, 32'd0}},
        '{1, 32'd149,        0, 1, '{0, 0, 0, 0, 0, 32'd0, 32'd0}},
        '{1, 32'd150,        0, 1, '{1, 0, 0, 0, 1, 32'd0, 32'd0}},
        '{1, 32'd1149,       0, 1, '{0, 0, 0, 0, 1, 32'd0, 32'd999}},
        '{1, 32'd1150,       0, 1, '{0, 1, 0, 0, 1, 32'd0, 32'd1000}},
        '{1, 32'd2000,       0, 0, '0},
        '{0, 32'd2010,       0, 0, '0},
        '{1, 32'd2020,       0, 0, '0},
        '{0, 32'd2030,       0, 0, '0},
        '{0, 32'd2080,       0, 1, '{0, 0, 1, 0, 0, 32'd0, 32'd0}},
        '{1, 32'd3000,       0, 0, '0},
        '{0, 32'd3010,       0, 0, '0},
        '{1, 32'd3020,       0, 0, '0},
        '{1, 32'd3070,       0, 0, '0},
        '{0, 32'd3100,       0, 0, '0},
        '{0, 32'd3150,       1, 1, '{0, 0, 1, 1, 0, 32'd1, 32'd0}},
        '{0, 32'd3200,       0, 1, '{0, 0, 0, 0, 0, 32'd0, 32'd0}},
        '{1, 32'hFFFF_FFF0,  0, 0, '0},
        '{1, 32'h0000_0022,  0, 0, '0},
        '{1, 32'h0000_0010,  0, 0, '0},
        '{0, 32'h0000_0020,  0, 0, '0},
        '{0, 32'hFFFF_FFFF,  1, 0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    bdlp_in_if  sample_ch ();
    bdlp_out_if result_ch ();
    bdlp_cfg_if cfg_ch ();

    button_debounce_long_press_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    t_btn_state            btn_state;
    t_time                 change_stamp;
    t_time                 press_stamp;
    logic                  long_done;
    logic                  held;
    t_count                click_total;
    logic [CFG_DATA_W-1:0] model_deb_time;
    logic [CFG_DATA_W-1:0] model_long_time;

    t_result     expected_results [$];
    t_time       stamp_ms;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned sample_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned press_seen = 0;
    int unsigned long_press_seen = 0;
    int unsigned release_seen = 0;
    int unsigned click_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("button_debounce_long_press_core_test failed");
        $finish;
    end

    function automatic void reset_button_model();
        btn_state = ST_RELEASED;
        change_stamp = '0;
        press_stamp = '0;
        long_done = 1'b0;
        held = 1'b0;
        click_total = '0;
        model_deb_time = DEBOUNCE_TIME_RESET;
        model_long_time = LONG_PRESS_TIME_RESET;
    endfunction

    function automatic t_result predict_button_result(t_sample s);
        t_result r;
        r = '0;
        case (btn_state)
            ST_DEB_PRESS: begin
                if (!s.raw_level) begin
                    btn_state = ST_RELEASED;
                end else if (t_time'(s.now_ms - change_stamp) >= t_time'(model_deb_time)) begin
                    btn_state = ST_PRESSED;
                    held = 1'b1;
                    press_stamp = s.now_ms;
                    long_done = 1'b0;
                    r.press_event = 1'b1;
                end
            end
            ST_PRESSED: begin
                if (!s.raw_level) begin
                    btn_state = ST_DEB_RELEASE;
                    change_stamp = s.now_ms;
                end else if (!long_done &&
                             t_time'(s.now_ms - press_stamp) >= t_time'(model_long_time)) begin
                    btn_state = ST_LONG;
                    long_done = 1'b1;
                    r.long_event = 1'b1;
                end
            end
            ST_LONG: begin
                if (!s.raw_level) begin
                    btn_state = ST_DEB_RELEASE;
                    change_stamp = s.now_ms;
                end
            end
            ST_DEB_RELEASE: begin
                if (s.raw_level) begin
                    btn_state = long_done ? ST_LONG : ST_PRESSED;
                end else if (t_time'(s.now_ms - change_stamp) >= t_time'(model_deb_time)) begin
                    btn_state = ST_RELEASED;
                    held = 1'b0;
                    r.release_event = 1'b1;
                    if (!long_done) begin
                        r.click_event = 1'b1;
                        click_total = click_total + 1'b1;
                    end
                end
            end
            default: begin
                btn_state = ST_RELEASED;
                if (s.raw_level) begin
                    btn_state = ST_DEB_PRESS;
                    change_stamp = s.now_ms;
                end
            end
        endcase
        r.is_held = held;
        r.clicks = click_total;
        r.hold_time = held ? t_time'(s.now_ms - press_stamp) : '0;
        if (s.clear_clicks) begin
            click_total = '0;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result item arrived with no sample waiting for it");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("press_event", 32'(want.press_event), 32'(result_ch.press_event));
                check_field("long_event", 32'(want.long_event), 32'(result_ch.long_event));
                check_field("release_event", 32'(want.release_event),
                            32'(result_ch.release_event));
                check_field("click_event", 32'(want.click_event), 32'(result_ch.click_event));
                check_field("is_held", 32'(want.is_held), 32'(result_ch.is_held));
                check_field("clicks", want.clicks, result_ch.clicks);
                check_field("hold_time", want.hold_time, result_ch.hold_time);
            end
            press_seen += result_ch.press_event;
            long_press_seen += result_ch.long_event;
            release_seen += result_ch.release_event;
            click_seen += result_ch.click_event;
        end
    end

    task automatic send_sample(input t_sample s, input logic typed, input t_result typed_want);
        t_result want;
        while ($urandom_range(99) < gap_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.raw_level <= s.raw_level;
        sample_ch.now_ms <= s.now_ms;
        sample_ch.clear_clicks <= s.clear_clicks;
        @(posedge i_clk);
        while (!sample_ch.ready) begin
            @(posedge i_clk);
        end
        want = predict_button_result(s);
        expected_results.push_back(typed ? typed_want : want);
        sample_count++;
    endtask

    task automatic send_level(input logic lvl, input int unsigned dt);
        t_sample s;
        stamp_ms = stamp_ms + dt;
        s.raw_level = lvl;
        s.now_ms = stamp_ms;
        s.clear_clicks = ($urandom_range(11) == 0);
        send_sample(s, 1'b0, '0);
    endtask

    task automatic hold_level(input logic lvl, input int unsigned span);
        int unsigned elapsed;
        int unsigned count;
        int unsigned step;
        int unsigned dt;
        elapsed = 0;
        count = 0;
        step = (span / 4 > 0) ? span / 4 : 1;
        while (elapsed < span || count < 2) begin
            dt = $urandom_range(step);
            elapsed += dt;
            count++;
            send_level(lvl, dt);
        end
    endtask

    task automatic chatter(input logic lvl);
        int unsigned n;
        n = $urandom_range(3, 1);
        repeat (n) begin
            send_level(lvl, $urandom_range(model_deb_time / 2));
            send_level(!lvl, $urandom_range(model_deb_time / 2));
        end
    endtask

    task automatic play_gesture();
        int unsigned pick;
        int unsigned n;
        int unsigned press_span;
        t_sample s;
        pick = $urandom_range(15);
        if (pick < 2) begin
            n = $urandom_range(6, 1);
            repeat (n) begin
                s.raw_level = 1'($urandom_range(1));
                s.now_ms = $urandom;
                s.clear_clicks = 1'($urandom_range(1));
                stamp_ms = s.now_ms;
                send_sample(s, 1'b0, '0);
            end
        end else begin
            if (pick == 2) begin
                stamp_ms = $urandom;
            end
            if ($urandom_range(2) == 0) begin
                chatter(1'b1);
            end
            if ($urandom_range(1) == 0) begin
                press_span = model_deb_time +
                             $urandom_range(model_long_time > 0 ? model_long_time - 1 : 0);
            end else begin
                press_span = model_deb_time + model_long_time +
                             $urandom_range(model_long_time / 2 + 5);
            end
            hold_level(1'b1, press_span);
            if ($urandom_range(2) == 0) begin
                chatter(1'b0);
            end
            hold_level(1'b0, model_deb_time + $urandom_range(20));
        end
    endtask

    task automatic drain_results(input int unsigned limit_cycles);
        int unsigned waited;
        waited = 0;
        sample_ch.valid <= 1'b0;
        while (expected_results.size() != 0 && waited < limit_cycles) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        if (idx == REG_DEBOUNCE_TIME) begin
            model_deb_time = data;
        end else if (idx == REG_LONG_PRESS_TIME) begin
            model_long_time = data;
        end
    endtask

    task automatic set_timing(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] lp);
        write_register(REG_DEBOUNCE_TIME, deb);
        write_register(REG_LONG_PRESS_TIME, lp);
        write_register(REG_OUT_OF_RANGE, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned phase_idx;
        int unsigned phase_end;
        logic        paused;
        t_sample     s;

        i_rst_n <= 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.raw_level <= 1'b0;
        sample_ch.now_ms <= '0;
        sample_ch.clear_clicks <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        reset_button_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            s.raw_level = DIRECTED_ROWS[i].raw_level;
            s.now_ms = DIRECTED_ROWS[i].now_ms;
            s.clear_clicks = DIRECTED_ROWS[i].clear_clicks;
            send_sample(s, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        stamp_ms = DIRECTED_ROWS[22].now_ms;
        drain_results(20000);

        for (phase_idx = 0; phase_idx < N_PHASES; phase_idx++) begin
            case (phase_idx)
                0: set_timing(DEBOUNCE_TIME_RESET, LONG_PRESS_TIME_RESET);
                1: set_timing(16'd0, 16'd0);
                2: set_timing(16'hFFFF, 16'hFFFF);
                3: set_timing(16'd0, 16'hFFFF);
                4: set_timing(16'hFFFF, 16'd0);
                5: set_timing(CFG_DATA_W'($urandom_range(30, 1)),
                              CFG_DATA_W'($urandom_range(300, 1)));
                6: set_timing(16'd20, 16'd400);
                default: set_timing(CFG_DATA_W'($urandom_range(200)),
                                    CFG_DATA_W'($urandom_range(3000)));
            endcase
            case (phase_idx % 4)
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct = 77;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 77;
                end
                default: begin
                    gap_pct = 26;
                    stall_pct = 26;
                end
            endcase
            phase_end = sample_count + ITEMS_PER_PHASE;
            paused = 1'b0;
            while (sample_count < phase_end) begin
                play_gesture();
                if (!paused && sample_count + ITEMS_PER_PHASE / 2 >= phase_end) begin
                    // Hold the sender back until every outstanding result is in.
                    drain_results(20000);
                    paused = 1'b1;
                end
            end
            drain_results(20000);
        end

        if (expected_results.size() != 0) begin
            $error("%0d result items never arrived", expected_results.size());
            mismatch_count++;
        end
        $display("Drove %0d samples through %0d timing settings and four idling mixes.",
                 sample_count, N_PHASES);
        $display("Observed %0d presses, %0d long presses, %0d releases and %0d clicks.",
                 press_seen, long_press_seen, release_seen, click_seen);
        if (mismatch_count == 0) begin
            $display("button_debounce_long_press_core_test passed");
        end else begin
            $display("button_debounce_long_press_core_test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bdlp_pkg.sv
hw/rtl/bdlp_in_if.sv
hw/rtl/bdlp_out_if.sv
hw/rtl/bdlp_cfg_if.sv
hw/rtl/button_debounce_long_press_core.sv
tb/sv/button_debounce_long_press_core_test.sv
